>>> hw/rtl/positional_list_buffer_top_defines.svh
// Assertion macros shared by the positional list buffer RTL.
`ifndef POSITIONAL_LIST_BUFFER_TOP_DEFINES_SVH
`define POSITIONAL_LIST_BUFFER_TOP_DEFINES_SVH

// Clocked property with explicit clock and reset.
`define PLB_ASSERT_CLK(clk_s, rst_s, lbl, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("positional list buffer check failed");

// Clocked property on the block clock and reset.
`define PLB_ASSERT(lbl, prop) `PLB_ASSERT_CLK(clk, rst, lbl, prop)

`endif

>>> hw/rtl/plb_pkg.sv
// Package: constants, codes and types of the positional list buffer.
`timescale 1ns / 1ps
`default_nettype none
package plb_pkg;

  localparam int CAPACITY   = 32;
  localparam int DUMP_LIMIT = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 6;
  localparam int LEN_W      = 6;
  localparam int DIDX_W     = 5;
  localparam int DATA_W     = 32;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_DELETE = 2'd1,
    K_UPDATE = 2'd2,
    K_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SH_RD   = 6'b000010,
    S_SH_WR   = 6'b000100,
    S_DUMP_RD = 6'b001000,
    S_DUMP_WR = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/positional_list_buffer_top.sv
// Top level: ordered word list held in one synchronous memory with shift sequencer.
//
// Usage: requests enter on in_valid/in_stall carrying kind, position and value.
// Results leave on out_valid/out_stall through one output register; a request
// is taken only while the block is idle and that register is free or draining.
// Sequence from acceptance to the result being loaded:
//   invalid position, full store, update, empty dump: the result is loaded
//   at the accepting edge itself.
//   insert and delete: each entry between the position and the end of the list
//   is moved by a read and then a write-back on the single memory port pair,
//   one entry at a time; insert then writes the new word into the opened hole,
//   and the result is loaded once the output register is free.
//   dump: each entry emitted is a memory read, then a load of the output
//   register, up to 32 entries; the final one carries last.
// Reset clears the state, the entry count and out_valid; the memory is not
// cleared, since only entries below the count are ever read.
// While the receiver stalls, the current result holds and the sequencer waits
// before loading the next one; no new request is taken until the work ends.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_buffer_top_defines.svh"
module positional_list_buffer_top
  import plb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               kind,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      entry_value,
  output logic [DIDX_W-1:0]             entry_index,
  output logic                          last,
  output logic [LEN_W-1:0]              length
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] rd_data;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               op_del, op_del_next;
  logic [IDX_W-1:0]   pos_r, pos_r_next;
  logic [DATA_W-1:0]  val_r, val_r_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [DIDX_W-1:0]  dump_idx, dump_idx_next;
  logic [DIDX_W-1:0]  dump_end, dump_end_next;
  logic               out_valid_next;
  status_t            res_status, res_status_next;
  logic [DATA_W-1:0]  res_value, res_value_next;
  logic [DIDX_W-1:0]  res_index, res_index_next;
  logic               res_last, res_last_next;
  logic [LEN_W-1:0]   res_len, res_len_next;

  logic              in_acc;
  logic              out_free;
  logic [CMP_W-1:0]  ext_count;
  logic [CMP_W-1:0]  ext_pos;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign ext_count = CMP_W'(count);
  assign ext_pos   = CMP_W'(position);

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    op_del_next     = op_del;
    pos_r_next      = pos_r;
    val_r_next      = val_r;
    idx_next        = idx;
    dump_idx_next   = dump_idx;
    dump_end_next   = dump_end;
    out_valid_next  = out_valid && out_stall;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_index_next  = res_index;
    res_last_next   = res_last;
    res_len_next    = res_len;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = rd_data;
    mem_re          = 1'b0;
    mem_raddr       = idx;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          res_value_next = '0;
          res_index_next = '0;
          res_last_next  = 1'b1;
          res_len_next   = LEN_W'(count);
          unique case (kind_t'(kind))
            K_INSERT: begin
              if (ext_pos > ext_count) begin
                out_valid_next  = 1'b1;
                res_status_next = ST_INVALID;
              end else if (count == CNT_W'(CAPACITY)) begin
                out_valid_next  = 1'b1;
                res_status_next = ST_FULL;
              end else begin
                op_del_next = 1'b0;
                pos_r_next  = IDX_W'(position);
                val_r_next  = value;
                idx_next    = IDX_W'(count);
                state_next  = S_SH_RD;
              end
            end
            K_DELETE: begin
              if (ext_pos >= ext_count) begin
                out_valid_next  = 1'b1;
                res_status_next = ST_INVALID;
              end else begin
                op_del_next = 1'b1;
                idx_next    = IDX_W'(position);
                state_next  = S_SH_RD;
              end
            end
            K_UPDATE: begin
              out_valid_next = 1'b1;
              if (ext_pos >= ext_count) begin
                res_status_next = ST_INVALID;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = IDX_W'(position);
                mem_wdata       = value;
                res_status_next = ST_OK;
              end
            end
            K_DUMP: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                res_status_next = ST_EMPTY;
              end else begin
                dump_idx_next = '0;
                dump_end_next = (ext_count > CMP_W'(DUMP_LIMIT)) ?
                                DIDX_W'(DUMP_LIMIT - 1) :
                                DIDX_W'(ext_count - CMP_W'(1));
                state_next    = S_DUMP_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_SH_RD: begin
        if (op_del) begin
          if (idx == IDX_W'(count - CNT_W'(1))) begin
            count_next = count - CNT_W'(1);
            state_next = S_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = idx + IDX_W'(1);
            state_next = S_SH_WR;
          end
        end else begin
          if (idx == pos_r) begin
            // Hole is open: drop the new word in.
            mem_we     = 1'b1;
            mem_waddr  = pos_r;
            mem_wdata  = val_r;
            count_next = count + CNT_W'(1);
            state_next = S_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = idx - IDX_W'(1);
            state_next = S_SH_WR;
          end
        end
      end

      S_SH_WR: begin
        // Write back the neighbor read last cycle; the next read never hits this entry.
        mem_we     = 1'b1;
        mem_waddr  = idx;
        mem_wdata  = rd_data;
        idx_next   = op_del ? (idx + IDX_W'(1)) : (idx - IDX_W'(1));
        state_next = S_SH_RD;
      end

      S_DUMP_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = IDX_W'(dump_idx);
        state_next = S_DUMP_WR;
      end

      S_DUMP_WR: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          res_status_next = ST_OK;
          res_value_next  = rd_data;
          res_index_next  = dump_idx;
          res_last_next   = (dump_idx == dump_end);
          res_len_next    = LEN_W'(count);
          if (dump_idx == dump_end) begin
            state_next = S_IDLE;
          end else begin
            dump_idx_next = dump_idx + DIDX_W'(1);
            state_next    = S_DUMP_RD;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          res_status_next = ST_OK;
          res_value_next  = '0;
          res_index_next  = '0;
          res_last_next   = 1'b1;
          res_len_next    = LEN_W'(count);
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_del     <= op_del_next;
    pos_r      <= pos_r_next;
    val_r      <= val_r_next;
    idx        <= idx_next;
    dump_idx   <= dump_idx_next;
    dump_end   <= dump_end_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_index  <= res_index_next;
    res_last   <= res_last_next;
    res_len    <= res_len_next;
  end

  assign status      = res_status;
  assign entry_value = res_value;
  assign entry_index = res_index;
  assign last        = res_last;
  assign length      = res_len;

  `PLB_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))
  `PLB_ASSERT(a_busy_stalls, (state != S_IDLE) |-> in_stall)
  `PLB_ASSERT(a_wr_after_rd, (state == S_SH_WR) |-> ($past(state) == S_SH_RD))
  `PLB_ASSERT(a_full_refused,
    (in_acc && (kind_t'(kind) == K_INSERT) && (count == CNT_W'(CAPACITY))
     && (ext_pos <= ext_count)) |=> (out_valid && (res_status == ST_FULL)
     && $stable(count)))

endmodule
`default_nettype wire
